FILE: hw/rtl/comment_marker_detector_defines.svh
// Assertion macros shared by the comment marker detector RTL.
`ifndef COMMENT_MARKER_DETECTOR_DEFINES_SVH
`define COMMENT_MARKER_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define CMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define CMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cmd_pkg.sv
// Shared constants for the comment marker detector: widths, register indexes, character codes, state codes.
package cmd_pkg;

	// Configuration port and register widths
	localparam int unsigned CFG_INDEX_BITS = 8;
	localparam int unsigned CFG_DATA_BITS  = 64;
	localparam int unsigned LEN_REG_BITS   = 4;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER_CHARS  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER_LENGTH = 8'd1;

	// Characters with comment syntax meaning
	localparam logic [7:0] CH_NUL     = 8'd0;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_STAR    = 8'd42;
	localparam logic [7:0] CH_SLASH   = 8'd47;

	// Scanner state codes
	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_SLASH_OPEN = 4'd1;
	localparam logic [3:0] ST_LINE       = 4'd2;
	localparam logic [3:0] ST_BODY       = 4'd3;
	localparam logic [3:0] ST_STAR       = 4'd4;
	localparam logic [3:0] ST_LONG_STAR  = 4'd5;
	localparam logic [3:0] ST_LONG       = 4'd6;
	localparam logic [3:0] ST_MATCHING   = 4'd7;
	localparam logic [3:0] ST_CLOSED     = 4'd8;

endpackage

FILE: hw/rtl/cmd_if.sv
// Valid/ready channel interfaces for characters, results and configuration writes.
interface cmd_char_if #(
	parameter int unsigned POSITION_BITS = 16
) ();
	logic                     valid;
	logic                     ready;
	logic [7:0]               character;
	logic [POSITION_BITS-1:0] position;

	modport source (output valid, output character, output position, input ready);
	modport sink   (input valid, input character, input position, output ready);
endinterface

interface cmd_result_if #(
	parameter int unsigned POSITION_BITS = 16
) ();
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [POSITION_BITS-1:0] comment_start;

	modport source (output valid, output found, output comment_start, input ready);
	modport sink   (input valid, input found, input comment_start, output ready);
endinterface

interface cmd_cfg_if ();
	logic                                valid;
	logic                                ready;
	logic [cmd_pkg::CFG_INDEX_BITS-1:0]  index;
	logic [cmd_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/comment_marker_detector.sv
// Comment marker detector: tracks C-style comments and flags block comments ending in a marker.
// One character word is taken per clock, and every word gives exactly one result word. A word
// is held in the input stage, where the comment state machine and the marker compare update
// the scan state, and its result is then held in the output register before it is offered on
// the result channel. Throughput is one word per cycle, set by the state update loop; the input
// stage drains, and the scan state updates, only when the result register is free or being
// drained. Configuration writes are always taken and apply from the next character on.
`include "comment_marker_detector_defines.svh"

module comment_marker_detector #(
	parameter int unsigned MAX_MARKER_LEN = 8,
	parameter int unsigned POSITION_BITS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	cmd_char_if.sink        chars,
	cmd_result_if.source    results,
	cmd_cfg_if.sink         cfg
);

	localparam int unsigned LEN_BITS    = $clog2(MAX_MARKER_LEN + 1);
	localparam int unsigned MARKER_BITS = 8 * MAX_MARKER_LEN;

	// Configuration registers
	logic [MARKER_BITS-1:0]           marker_chars_q;
	logic [cmd_pkg::LEN_REG_BITS-1:0] marker_length_q;

	// Input stage
	logic                     valid_s1;
	logic [7:0]               char_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	// Scan state
	logic [3:0]               st_q;
	logic                     flag_q;
	logic [LEN_BITS-1:0]      cnt_q;
	logic [POSITION_BITS-1:0] open_pos_q;

	// Output stage
	logic                     valid_s2;
	logic                     found_s2;
	logic [POSITION_BITS-1:0] start_s2;

	logic                     adv_s1;
	logic                     take_in;

	logic [3:0]               st_cur;
	logic [3:0]               st_n;
	logic                     flag_n;
	logic [LEN_BITS-1:0]      cnt_n;
	logic [POSITION_BITS-1:0] open_pos_n;
	logic                     hit;

	logic [LEN_BITS-1:0]      len_eff;
	logic [LEN_BITS-1:0]      scan_cnt;
	logic [LEN_BITS-1:0]      scan_c;
	logic [7:0]               scan_byte;
	logic [3:0]               scan_st;
	logic [LEN_BITS-1:0]      scan_cnt_n;
	logic                     scan_flag;

	// Handshake: stage 1 drains into the result register when it is free or being taken
	assign adv_s1        = valid_s1 && (!valid_s2 || results.ready);
	assign take_in       = chars.valid && chars.ready;
	assign chars.ready   = !valid_s1 || adv_s1;
	assign cfg.ready     = 1'b1;

	assign results.valid         = valid_s2;
	assign results.found         = found_s2;
	assign results.comment_start = start_s2;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_chars_q  <= '0;
			marker_length_q <= cmd_pkg::LEN_REG_BITS'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				cmd_pkg::REG_MARKER_CHARS:  marker_chars_q  <= cfg.data[MARKER_BITS-1:0];
				cmd_pkg::REG_MARKER_LENGTH: marker_length_q <= cfg.data[cmd_pkg::LEN_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective marker length, clamped to the stored width
	assign len_eff = (marker_length_q > cmd_pkg::LEN_REG_BITS'(MAX_MARKER_LEN))
		? LEN_BITS'(MAX_MARKER_LEN) : LEN_BITS'(marker_length_q);

	// Marker compare: restart at zero after a star or on a slash, wrap after a full match
	always_comb begin
		scan_cnt  = (st_cur == cmd_pkg::ST_STAR || char_s1 == cmd_pkg::CH_SLASH) ? '0 : cnt_q;
		scan_c    = (scan_cnt >= len_eff) ? '0 : scan_cnt;
		scan_byte = '0;
		for (int k = 0; k < MAX_MARKER_LEN; k++) begin
			if (scan_c == LEN_BITS'(k))
				scan_byte = marker_chars_q[8*k +: 8];
		end
		if (len_eff != '0 && char_s1 == scan_byte) begin
			scan_st    = cmd_pkg::ST_MATCHING;
			scan_cnt_n = scan_c + LEN_BITS'(1);
			scan_flag  = (scan_cnt_n == len_eff);
		end else begin
			scan_st    = cmd_pkg::ST_BODY;
			scan_cnt_n = '0;
			scan_flag  = 1'b0;
		end
	end

	// Comment state machine
	always_comb begin
		st_cur     = (st_q > cmd_pkg::ST_CLOSED) ? cmd_pkg::ST_IDLE : st_q;
		st_n       = st_cur;
		flag_n     = flag_q;
		cnt_n      = cnt_q;
		open_pos_n = open_pos_q;
		hit        = 1'b0;
		if (char_s1 == cmd_pkg::CH_NUL || char_s1 == cmd_pkg::CH_NEWLINE) begin
			case (st_cur)
				cmd_pkg::ST_LINE, cmd_pkg::ST_SLASH_OPEN: st_n = cmd_pkg::ST_IDLE;
				cmd_pkg::ST_CLOSED: begin
					st_n = cmd_pkg::ST_IDLE;
					hit  = flag_q;
				end
				cmd_pkg::ST_BODY, cmd_pkg::ST_STAR, cmd_pkg::ST_LONG_STAR,
				cmd_pkg::ST_MATCHING: begin
					st_n   = cmd_pkg::ST_LONG;
					flag_n = 1'b0;
				end
				default: ;
			endcase
		end else if (char_s1 == cmd_pkg::CH_SLASH) begin
			case (st_cur)
				cmd_pkg::ST_IDLE:       st_n = cmd_pkg::ST_SLASH_OPEN;
				cmd_pkg::ST_SLASH_OPEN: st_n = cmd_pkg::ST_LINE;
				cmd_pkg::ST_CLOSED: begin
					st_n = cmd_pkg::ST_SLASH_OPEN;
					hit  = flag_q;
				end
				cmd_pkg::ST_STAR:      st_n = cmd_pkg::ST_CLOSED;
				cmd_pkg::ST_LONG_STAR: st_n = cmd_pkg::ST_IDLE;
				cmd_pkg::ST_BODY, cmd_pkg::ST_MATCHING: begin
					st_n   = scan_st;
					cnt_n  = scan_cnt_n;
					flag_n = scan_flag;
				end
				default: ;
			endcase
		end else if (char_s1 == cmd_pkg::CH_STAR) begin
			case (st_cur)
				cmd_pkg::ST_SLASH_OPEN: begin
					st_n       = cmd_pkg::ST_BODY;
					open_pos_n = pos_s1;
					flag_n     = 1'b0;
					cnt_n      = '0;
				end
				cmd_pkg::ST_CLOSED: begin
					st_n = cmd_pkg::ST_IDLE;
					hit  = flag_q;
				end
				cmd_pkg::ST_BODY, cmd_pkg::ST_MATCHING: st_n = cmd_pkg::ST_STAR;
				cmd_pkg::ST_STAR: flag_n = 1'b0;
				cmd_pkg::ST_LONG: st_n = cmd_pkg::ST_LONG_STAR;
				default: ;
			endcase
		end else begin
			case (st_cur)
				cmd_pkg::ST_SLASH_OPEN: st_n = cmd_pkg::ST_IDLE;
				cmd_pkg::ST_CLOSED: begin
					st_n = cmd_pkg::ST_IDLE;
					hit  = flag_q;
				end
				cmd_pkg::ST_STAR, cmd_pkg::ST_BODY, cmd_pkg::ST_MATCHING: begin
					st_n   = scan_st;
					cnt_n  = scan_cnt_n;
					flag_n = scan_flag;
				end
				cmd_pkg::ST_LONG_STAR: st_n = cmd_pkg::ST_LONG;
				default: ;
			endcase
		end
	end

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= chars.character;
			pos_s1  <= chars.position;
		end
	end

	// Scan state update, one word per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= cmd_pkg::ST_IDLE;
			flag_q     <= 1'b0;
			cnt_q      <= '0;
			open_pos_q <= '0;
		end else if (adv_s1) begin
			st_q       <= st_n;
			flag_q     <= flag_n;
			cnt_q      <= cnt_n;
			open_pos_q <= open_pos_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || results.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			found_s2 <= hit;
			start_s2 <= open_pos_n;
		end
	end

	// Checks
	`CMD_ASSERT_NOW(a_hit_only_after_close, adv_s1 && hit, st_cur == cmd_pkg::ST_CLOSED,
		"found raised outside the word after a close")
	`CMD_ASSERT_NOW(a_flag_needs_count, flag_q, cnt_q != '0,
		"match flag set with an empty match count")
	`CMD_ASSERT_NOW(a_count_in_range, 1'b1, cnt_q <= LEN_BITS'(MAX_MARKER_LEN),
		"match count beyond the marker width")
	`CMD_ASSERT_NEXT(a_state_holds_on_stall, valid_s1 && valid_s2 && !results.ready,
		$stable(st_q) && $stable(cnt_q) && $stable(flag_q),
		"scan state moved while the result register was stalled")

endmodule
